// File: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescape block.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // decoder modes: normal, after backslash, waiting for hex digit 1..4
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_HEX1   = 3'd2,
        MODE_HEX2   = 3'd3,
        MODE_HEX3   = 3'd4,
        MODE_HEX4   = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_END    = 2'd1,
        KIND_BADESC = 2'd2,
        KIND_BADHEX = 2'd3
    } t_kind;

    localparam logic [7:0] CHR_QUOTE = 8'h22;
    localparam logic [7:0] CHR_BSL   = 8'h5C;
    localparam logic [7:0] CHR_SLASH = 8'h2F;
    localparam logic [7:0] CHR_B     = 8'h62;
    localparam logic [7:0] CHR_F     = 8'h66;
    localparam logic [7:0] CHR_N     = 8'h6E;
    localparam logic [7:0] CHR_R     = 8'h72;
    localparam logic [7:0] CHR_T     = 8'h74;
    localparam logic [7:0] CHR_U     = 8'h75;

    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;

    // up to three results caused by one input byte; all data when count > 1
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
        t_kind           kind;
    } t_group;

    // returns {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b1, 4'(c - 8'h37)};
        end
        return v;
    endfunction

endpackage

// File: rtl/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Escape decoder: holds the mode and hex accumulator, turns one byte into a
// group of zero to three results.
// ----------------------------------------------------------------------------
module jsu_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_byte,
    input  logic            i_advance,
    output jsu_pkg::t_group o_group
);

    jsu_pkg::t_mode   r_mode, n_mode;
    logic [11:0]      r_hex, n_hex;
    logic [4:0]       hv;
    logic [15:0]      cp;
    jsu_pkg::t_group  grp;

    assign hv = jsu_pkg::hex_value(i_byte);
    assign cp = {r_hex, hv[3:0]};

    always_comb begin
        n_mode     = r_mode;
        n_hex      = r_hex;
        grp.count  = 2'd0;
        grp.bytes  = '0;
        grp.kind   = jsu_pkg::KIND_DATA;
        case (r_mode)
            jsu_pkg::MODE_ESC: begin
                grp.count = 2'd1;
                n_mode    = jsu_pkg::MODE_NORMAL;
                case (i_byte)
                    jsu_pkg::CHR_QUOTE: grp.bytes[0] = jsu_pkg::CHR_QUOTE;
                    jsu_pkg::CHR_BSL:   grp.bytes[0] = jsu_pkg::CHR_BSL;
                    jsu_pkg::CHR_SLASH: grp.bytes[0] = jsu_pkg::CHR_SLASH;
                    jsu_pkg::CHR_B:     grp.bytes[0] = 8'h08;
                    jsu_pkg::CHR_F:     grp.bytes[0] = 8'h0C;
                    jsu_pkg::CHR_N:     grp.bytes[0] = 8'h0A;
                    jsu_pkg::CHR_R:     grp.bytes[0] = 8'h0D;
                    jsu_pkg::CHR_T:     grp.bytes[0] = 8'h09;
                    jsu_pkg::CHR_U: begin
                        grp.count = 2'd0;
                        n_mode    = jsu_pkg::MODE_HEX1;
                        n_hex     = 12'd0;
                    end
                    default: begin
                        grp.kind = jsu_pkg::KIND_BADESC;
                        n_hex    = 12'd0;
                    end
                endcase
            end
            jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3: begin
                if (!hv[4]) begin
                    grp.count = 2'd1;
                    grp.kind  = jsu_pkg::KIND_BADHEX;
                    n_mode    = jsu_pkg::MODE_NORMAL;
                    n_hex     = 12'd0;
                end else begin
                    n_hex = {r_hex[7:0], hv[3:0]};
                    case (r_mode)
                        jsu_pkg::MODE_HEX1: n_mode = jsu_pkg::MODE_HEX2;
                        jsu_pkg::MODE_HEX2: n_mode = jsu_pkg::MODE_HEX3;
                        default:            n_mode = jsu_pkg::MODE_HEX4;
                    endcase
                end
            end
            jsu_pkg::MODE_HEX4: begin
                n_mode = jsu_pkg::MODE_NORMAL;
                n_hex  = 12'd0;
                if (!hv[4]) begin
                    grp.count = 2'd1;
                    grp.kind  = jsu_pkg::KIND_BADHEX;
                end else if (cp[15:7] == 9'd0) begin
                    grp.count    = 2'd1;
                    grp.bytes[0] = {1'b0, cp[6:0]};
                end else if (cp[15:11] == 5'd0) begin
                    grp.count    = 2'd2;
                    grp.bytes[0] = jsu_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]};
                    grp.bytes[1] = jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]};
                end else begin
                    grp.count    = 2'd3;
                    grp.bytes[0] = jsu_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]};
                    grp.bytes[1] = jsu_pkg::UTF8_CONT | {2'b00, cp[11:6]};
                    grp.bytes[2] = jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]};
                end
            end
            default: begin
                // normal mode; unused codes behave the same
                if (i_byte == jsu_pkg::CHR_BSL) begin
                    n_mode = jsu_pkg::MODE_ESC;
                end else if (i_byte == jsu_pkg::CHR_QUOTE) begin
                    grp.count = 2'd1;
                    grp.kind  = jsu_pkg::KIND_END;
                    n_mode    = jsu_pkg::MODE_NORMAL;
                    n_hex     = 12'd0;
                end else begin
                    grp.count    = 2'd1;
                    grp.bytes[0] = i_byte;
                    n_mode       = jsu_pkg::MODE_NORMAL;
                end
            end
        endcase
    end

    assign o_group = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jsu_pkg::MODE_NORMAL;
            r_hex  <= 12'd0;
        end else if (i_advance) begin
            r_mode <= n_mode;
            r_hex  <= n_hex;
        end
    end

endmodule

// File: rtl/jsu_out_buf.sv
// ----------------------------------------------------------------------------
// jsu_out_buf
// Result register: holds one result group and hands its entries out one
// request at a time, taking the next group as the last entry leaves.
// ----------------------------------------------------------------------------
module jsu_out_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  jsu_pkg::t_group i_group,
    output logic            o_free,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_byte,
    output logic [1:0]      o_kind,
    output logic            o_last
);

    logic            r_valid;
    jsu_pkg::t_group r_grp;
    logic [1:0]      r_idx;
    logic            is_last;

    assign is_last = (r_idx == r_grp.count - 2'd1);
    assign o_free  = !r_valid || (i_ready && is_last);
    assign o_valid = r_valid;
    assign o_byte  = r_grp.bytes[r_idx];
    assign o_kind  = r_grp.kind;
    assign o_last  = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load && o_free) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (r_valid && i_ready) begin
            if (is_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_grp <= i_group;
        end
    end

endmodule

// File: rtl/json_string_unescape_top.sv
// ----------------------------------------------------------------------------
// json_string_unescape_top
// Streaming decoder for the body of a JSON string, emitting UTF-8 bytes.
// ----------------------------------------------------------------------------
// Bytes of a string body enter one per request after the opening quote.
// Each byte is registered, decoded combinationally and its results (none
// for a backslash, 'u' and the first three hex digits, three at most for
// a \u escape) go to a result register handing out one result per cycle
// while the output is ready. A new byte is taken every cycle while the
// output is ready and each byte yields at most one result; else the next
// byte waits until the single result port has taken all earlier results.
// Results pass the input register and the result register. An unescaped
// quote yields an end result and returns the decoder to its reset state;
// bad escapes and bad hex digits yield an error result and do the same.
module json_string_unescape_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_kind,
    output logic       o_last
);

    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    jsu_pkg::t_group grp;
    logic            buf_free;
    logic            consume;

    // a byte without results moves on regardless of the output side
    assign consume    = r_in_valid && (grp.count == 2'd0 || buf_free);
    assign o_in_ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
        end
    end

    jsu_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (r_in_byte),
        .i_advance (consume),
        .o_group   (grp)
    );

    jsu_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (consume && grp.count != 2'd0),
        .i_group (grp),
        .o_free  (buf_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_byte  (o_out_byte),
        .o_kind  (o_kind),
        .o_last  (o_last)
    );

`ifndef SYNTH
    // a held input byte is never overwritten before it is decoded
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !consume |=> r_in_valid && $stable(r_in_byte))
        else $error("input register overwritten");

    // end and error results stand alone
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != jsu_pkg::KIND_DATA |-> o_last)
        else $error("non-data result not last");

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == jsu_pkg::KIND_END |-> o_out_byte == 8'd0)
        else $error("end result carries data");

    // a multi-byte group only comes from data
    a_group_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && grp.count > 2'd1 |-> grp.kind == jsu_pkg::KIND_DATA)
        else $error("multi-result group with error kind");
`endif

endmodule
